// File: rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque package
// Shared constants, operation and status codes, and the types that pass
// between the top level, the cell row and the cells.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEQ_DEPTH   = 16;
    localparam int OP_W        = 3;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int IN_BITS     = OP_W + VALUE_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } deq_status_t;

    // Command broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_SHIFT_R,
        CMD_SHIFT_L,
        CMD_SHIFT_L_MATCH,
        CMD_APPEND,
        CMD_TRIM
    } deq_cmd_t;

    // Status the row reports back to the control logic.
    typedef struct packed {
        logic               front_match;
        logic               back_match;
        logic               any_match;
        logic [VALUE_W-1:0] front_data;
        logic [VALUE_W-1:0] back_data;
    } deq_flags_t;

endpackage

// File: rtl/deq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque cell
// Holds one entry and its valid bit, and moves data to or from its
// neighbors under the broadcast command.
// ----------------------------------------------------------------------------
module deq_cell
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  deq_pkg::deq_cmd_t              cmd,
    input  logic [deq_pkg::VALUE_W-1:0]    value,
    input  logic [deq_pkg::VALUE_W-1:0]    left_data,
    input  logic                           left_valid,
    input  logic [deq_pkg::VALUE_W-1:0]    right_data,
    input  logic                           right_valid,
    input  logic                           seen_in,
    output logic [deq_pkg::VALUE_W-1:0]    data,
    output logic                           valid,
    output logic                           seen_out,
    output logic                           match,
    output logic                           last_match,
    output logic [deq_pkg::VALUE_W-1:0]    last_data
);
    import deq_pkg::*;

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               valid_reg;
    logic               valid_next;
    logic               last;

    assign match      = valid_reg && (data_reg == value);
    assign last       = valid_reg && !right_valid;
    assign seen_out   = seen_in | match;
    assign last_match = last & match;
    assign last_data  = last ? data_reg : '0;
    assign data       = data_reg;
    assign valid      = valid_reg;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (cmd)
            CMD_SHIFT_R:
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            CMD_SHIFT_L:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            CMD_SHIFT_L_MATCH:
            begin
                // Cells from the first match onward close the gap.
                if (seen_in || match)
                begin
                    data_next  = right_data;
                    valid_next = right_valid;
                end
            end
            CMD_APPEND:
            begin
                if (left_valid && !valid_reg)
                begin
                    data_next  = value;
                    valid_next = 1'b1;
                end
            end
            CMD_TRIM:
            begin
                if (last)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// File: rtl/deq_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque cell row
// Chain of cells with the front entry in cell zero; entries stay packed
// toward the front. Collects match and back-entry status for the control.
// ----------------------------------------------------------------------------
module deq_row
#(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  deq_pkg::deq_cmd_t              cmd,
    input  logic [deq_pkg::VALUE_W-1:0]    value,
    output deq_pkg::deq_flags_t            flags
);
    import deq_pkg::*;

    logic [VALUE_W-1:0] data_a      [DEPTH];
    logic [VALUE_W-1:0] last_data_a [DEPTH];
    logic [DEPTH-1:0]   valid_a;
    logic [DEPTH-1:0]   match_a;
    logic [DEPTH-1:0]   last_match_a;
    logic [DEPTH:0]     seen_a;

    assign seen_a[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_W-1:0] l_data;
        logic               l_valid;
        logic [VALUE_W-1:0] r_data;
        logic               r_valid;

        if (i == 0)
        begin : g_head
            assign l_data  = value;
            assign l_valid = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_data  = data_a[i-1];
            assign l_valid = valid_a[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_data  = data_a[i+1];
            assign r_valid = valid_a[i+1];
        end

        deq_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .value       (value),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .seen_in     (seen_a[i]),
            .data        (data_a[i]),
            .valid       (valid_a[i]),
            .seen_out    (seen_a[i+1]),
            .match       (match_a[i]),
            .last_match  (last_match_a[i]),
            .last_data   (last_data_a[i])
        );
    end

    always_comb
    begin
        logic [VALUE_W-1:0] back;
        back = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back = back | last_data_a[i];
        end
        flags.front_match = match_a[0];
        flags.back_match  = |last_match_a;
        flags.any_match   = seen_a[DEPTH];
        flags.front_data  = data_a[0];
        flags.back_data   = back;
    end

endmodule

// File: rtl/double_ended_queue_with_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue with delete by value
// Bounded deque of signed 32-bit values with push and pop at both ends and
// delete of one entry by value, built as a shifting row of cells.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata fields (lowest bit first)
//  s_axis    in         operation[2:0], value[34:3], zero fill to 40 bits
//  m_axis    out        popped_value[31:0], status[33:32], fill_count, zero fill
//
// One request is accepted per cycle; its result appears in the output
// register on the next cycle. The whole row compares and shifts in the
// accepting cycle, so the match chain across DEPTH cells sets the clock period.
// A request is taken while the output register is empty or being drained.
// Reset clears the valid bits and fill count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_queue_with_delete
#(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // operation, value
    input  logic [deq_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // popped_value, status, fill_count
    output logic [((deq_pkg::VALUE_W + deq_pkg::STATUS_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                                m_tdata
);
    import deq_pkg::*;

    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OUT_BITS = VALUE_W + STATUS_W + CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] value;
    logic               accept;

    deq_cmd_t           cmd;
    deq_flags_t         flags;
    deq_status_t        status;
    logic [VALUE_W-1:0] popped;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    assign operation = s_tdata[OP_W-1:0];
    assign value     = s_tdata[OP_W +: VALUE_W];
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        logic full;
        logic empty;
        full       = (count_reg == FULL_CNT);
        empty      = (count_reg == '0);
        cmd        = CMD_HOLD;
        status     = ST_OK;
        popped     = '0;
        count_next = count_reg;
        case (operation)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd        = (operation == OP_PUSH_FRONT) ? CMD_SHIFT_R : CMD_APPEND;
                    count_next = count_reg + ONE_CNT;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    cmd        = CMD_SHIFT_L;
                    popped     = flags.front_data;
                    count_next = count_reg - ONE_CNT;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    cmd        = CMD_TRIM;
                    popped     = flags.back_data;
                    count_next = count_reg - ONE_CNT;
                end
            end
            OP_DELETE:
            begin
                // Front entry wins, then the back entry, then the first match.
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (flags.front_match)
                begin
                    cmd        = CMD_SHIFT_L;
                    count_next = count_reg - ONE_CNT;
                end
                else if (flags.back_match)
                begin
                    cmd        = CMD_TRIM;
                    count_next = count_reg - ONE_CNT;
                end
                else if (flags.any_match)
                begin
                    cmd        = CMD_SHIFT_L_MATCH;
                    count_next = count_reg - ONE_CNT;
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                cmd = CMD_HOLD;
            end
        endcase
        if (!accept)
        begin
            cmd = CMD_HOLD;
        end
    end

    deq_row
    #(
        .DEPTH (DEPTH)
    )
    u_row
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .value (value),
        .flags (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= OUT_W'({count_next, status, popped});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque with delete testbench
// Sends push, pop, delete and unused opcodes through the stream port and keeps
// a queue-based predictor of the store. Every result is checked field by field
// against the oldest prediction, under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
    import deq_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int FILL_W       = $clog2(DEQ_DEPTH + 1);
    localparam int OUT_TDATA_W  = ((VALUE_W + STATUS_W + FILL_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 550;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 80;
    localparam int HOLD_AFTER   = 150;
    localparam int DRAIN_CYCLES = 4;
    localparam int POOL_MAX     = 24;

    localparam logic [OP_W-1:0]    OP_RSVD_LO = 3'd5;
    localparam logic [OP_W-1:0]    OP_RSVD_HI = 3'd7;
    localparam logic [VALUE_W-1:0] VAL_MIN    = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX    = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] VAL_ALT    = 32'haaaa_aaaa;
    localparam logic [VALUE_W-1:0] VAL_ABSENT = 32'h1234_5678;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
    } deq_req_t;

    typedef struct {
        logic [VALUE_W-1:0] popped;
        deq_status_t        status;
        logic [FILL_W-1:0]  fill;
    } deq_resp_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // operation, value
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // popped_value, status, fill_count
    logic [OUT_TDATA_W-1:0] m_tdata;

    deq_req_t           req_pending[$];
    deq_resp_t          resp_expected[$];
    logic [VALUE_W-1:0] held_values[$];
    logic [VALUE_W-1:0] pushed_pool[$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    int  op_seen[8];
    int  status_seen[4];
    int  peak_fill = 0;
    bit  offering = 1'b0;
    bit  req_taken = 1'b0;
    int  gap_left = 0;
    int  burst_left = 0;
    int  sink_mode = 0;
    int  mode_left = 0;
    int  sink_phase = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;

    double_ended_queue_with_delete #(.DEPTH(DEQ_DEPTH)) uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // Applies one request to the predicted store and returns its result.
    function automatic deq_resp_t apply_request(deq_req_t r);
        deq_resp_t rsp;
        int        hit;
        rsp.popped = '0;
        rsp.status = ST_OK;
        hit = -1;
        case (r.op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (held_values.size() >= DEQ_DEPTH)
                    rsp.status = ST_FULL;
                else if (r.op == OP_PUSH_FRONT)
                    held_values.push_front(r.value);
                else
                    held_values.push_back(r.value);
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (held_values.size() == 0)
                    rsp.status = ST_EMPTY;
                else if (r.op == OP_POP_FRONT)
                    rsp.popped = held_values.pop_front();
                else
                    rsp.popped = held_values.pop_back();
            end
            OP_DELETE:
            begin
                if (held_values.size() == 0)
                    rsp.status = ST_EMPTY;
                else if (held_values[0] == r.value)
                    void'(held_values.pop_front());
                // The back end is tried before any match in the middle.
                else if (held_values[held_values.size() - 1] == r.value)
                    void'(held_values.pop_back());
                else
                begin
                    for (int k = 0; k < held_values.size(); k++)
                        if (hit < 0 && held_values[k] == r.value)
                            hit = k;
                    if (hit < 0)
                        rsp.status = ST_NOT_FOUND;
                    else
                        held_values.delete(hit);
                end
            end
            default:
            begin
            end
        endcase
        rsp.fill = FILL_W'(held_values.size());
        return rsp;
    endfunction

    function automatic void add_req(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
        deq_req_t r;
        r.op = op;
        r.value = value;
        req_pending.push_back(r);
    endfunction

    // Often a small set of values so that duplicates and matches are common.
    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return VALUE_W'($signed($urandom_range(0, 7)) - 4);
        else if (roll == 4)
        begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom();
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got_v,
                                   input logic [VALUE_W-1:0] want_v);
        $display("MISMATCH result %0d, %s: got 0x%08h, expected 0x%08h",
                 results_seen, what, got_v, want_v);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : monitor_proc
        deq_req_t  req;
        deq_resp_t want;
        deq_resp_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.popped = m_tdata[VALUE_W-1:0];
                got.status = deq_status_t'(m_tdata[VALUE_W +: STATUS_W]);
                got.fill = m_tdata[VALUE_W + STATUS_W +: FILL_W];
                if (resp_expected.size() == 0)
                    report_mismatch("result with no request pending", got.popped, '0);
                else
                begin
                    want = resp_expected.pop_front();
                    if (got.popped !== want.popped)
                        report_mismatch("popped_value", got.popped, want.popped);
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.fill !== want.fill)
                        report_mismatch("fill_count", 32'(got.fill), 32'(want.fill));
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                req.op = s_tdata[OP_W-1:0];
                req.value = s_tdata[OP_W +: VALUE_W];
                want = apply_request(req);
                resp_expected.push_back(want);
                op_seen[req.op]++;
                status_seen[want.status]++;
                if (int'(want.fill) > peak_fill)
                    peak_fill = want.fill;
                req_taken = 1'b1;
            end
        end
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin : drive_proc
        deq_req_t item;
        if (rst_n)
        begin
            if (req_taken)
            begin
                offering = 1'b0;
                req_taken = 1'b0;
            end
            if (!offering)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (req_pending.size() != 0)
                begin
                    item = req_pending.pop_front();
                    s_tdata <= IN_TDATA_W'({item.value, item.op});
                    offering = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            s_tvalid <= offering;
        end
    end

    // Receiver: switches between always ready, random and one-in-four, with
    // one long hold-off that backs the block up into its input.
    always @(negedge clk)
    begin : sink_proc
        bit ready_next;
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                sink_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 64);
            end
            else
                mode_left--;
            sink_phase++;
            if (!long_hold_done && results_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (sink_mode == 0)
                ready_next = 1'b1;
            else if (sink_mode == 1)
                ready_next = $urandom_range(0, 1);
            else
                ready_next = (sink_phase % 4) == 0;
            m_tready <= ready_next;
        end
    end

    always @(posedge clk)
    begin : watchdog_proc
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no request moved for %0d cycles, %0d results outstanding",
                         idle_cycles, resp_expected.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin : main_proc
        int                 produced;
        int                 phase_kind;
        int                 phase_len;
        int                 roll;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        int                 push_pct[4];
        int                 pop_pct[4];
        int                 del_pct[4];

        // Empty store, unused opcodes, then a known mix of values.
        add_req(OP_POP_FRONT, '0);
        add_req(OP_POP_BACK, '0);
        add_req(OP_DELETE, '0);
        for (int c = OP_RSVD_LO; c <= OP_RSVD_HI; c++)
            add_req(OP_W'(c), VAL_ALT);
        add_req(OP_PUSH_FRONT, VAL_MIN);
        add_req(OP_PUSH_BACK, VAL_MAX);
        add_req(OP_PUSH_BACK, 32'd9);
        add_req(OP_PUSH_FRONT, 32'd9);
        add_req(OP_PUSH_BACK, VAL_ALT);
        add_req(OP_PUSH_BACK, '0);
        // Delete at the front, at the back, in the middle, and a miss.
        add_req(OP_DELETE, 32'd9);
        add_req(OP_DELETE, '0);
        add_req(OP_DELETE, 32'd9);
        add_req(OP_DELETE, VAL_ABSENT);
        // A match at the back wins over an earlier one in the middle.
        add_req(OP_PUSH_BACK, VAL_MAX);
        add_req(OP_DELETE, VAL_MAX);
        add_req(OP_POP_FRONT, '0);
        add_req(OP_POP_BACK, '0);
        add_req(OP_POP_BACK, '0);

        // Phases: fill, drain, mixed and delete-heavy.
        push_pct = '{80, 15, 40, 35};
        pop_pct  = '{10, 65, 30, 10};
        del_pct  = '{8, 18, 27, 53};
        produced = 0;
        while (produced < RANDOM_ITEMS)
        begin
            phase_kind = $urandom_range(0, 3);
            phase_len = $urandom_range(15, 50);
            for (int n = 0; n < phase_len && produced < RANDOM_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct[phase_kind])
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else if (roll < push_pct[phase_kind] + pop_pct[phase_kind])
                    op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                else if (roll < push_pct[phase_kind] + pop_pct[phase_kind] + del_pct[phase_kind])
                    op = OP_DELETE;
                else
                    op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
                if (op == OP_DELETE && pushed_pool.size() != 0 && $urandom_range(0, 3) != 0)
                    value = pushed_pool[$urandom_range(0, pushed_pool.size() - 1)];
                else
                    value = pick_value();
                if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
                begin
                    pushed_pool.push_back(value);
                    if (pushed_pool.size() > POOL_MAX)
                        void'(pushed_pool.pop_front());
                end
                add_req(op, value);
                produced++;
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_pending.size() != 0 || offering || resp_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d push, %0d pop, %0d delete, %0d unused opcode;",
                 results_seen, op_seen[OP_PUSH_FRONT] + op_seen[OP_PUSH_BACK],
                 op_seen[OP_POP_FRONT] + op_seen[OP_POP_BACK], op_seen[OP_DELETE],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        $display("outcomes %0d ok, %0d empty, %0d not found, %0d full; peak fill %0d of %0d.",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
                 status_seen[ST_FULL], peak_fill, DEQ_DEPTH);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
